// File: rtl/leap_second_clock_adjust_assert.svh
// Assertion macros for the leap second adjust block; empty under synthesis.
`ifndef LEAP_SECOND_CLOCK_ADJUST_ASSERT_SVH
`define LEAP_SECOND_CLOCK_ADJUST_ASSERT_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LSCA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lsca: same-cycle check failed");
// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LSCA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lsca: next-cycle check failed");
`else
`define LSCA_ASSERT_SAME(lbl, ante, cons)
`define LSCA_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/lsca_pkg.sv
// Shared types and constants of the leap second adjust block.
`timescale 1ns / 1ps
package lsca_pkg;

  localparam int SEC_W  = 34;
  localparam int DAYS_W = 18;   // day count of any 34-bit time
  localparam int REM_W  = 17;   // remainder below one day
  localparam int PROD_W = 35;   // day count times seconds per day
  localparam int YD_W   = 9;    // day of year incl. year length

  // day count = (seconds >> 7) / 675, the divide done as a reciprocal multiply
  localparam int DAY_SHIFT   = 7;                    // 86400 = 675 * 2^7
  localparam int HI_W        = SEC_W - DAY_SHIFT;    // shifted seconds
  localparam int RECIP_W     = 28;
  localparam int RECIP_SHIFT = 37;
  localparam int DPROD_W     = HI_W + RECIP_W;
  localparam logic [RECIP_W-1:0] DAY_RECIP = 28'd203613265;  // ceil(2^37 / 675)

  localparam logic [SEC_W-1:0]  SEC_MAX  = '1;
  localparam logic [REM_W-1:0]  DAY_SECS = 17'd86400;
  localparam logic [PROD_W-1:0] PROD_LIM = 35'h4_0000_0000;  // 2^34

  localparam logic [YD_W-1:0] YEAR_DAYS      = 9'd365;
  localparam logic [YD_W-1:0] LEAP_YEAR_DAYS = 9'd366;

  // 1970 modulo 4, 100 and 400
  localparam logic [1:0] Y4_INIT   = 2'd2;
  localparam logic [6:0] Y100_INIT = 7'd70;
  localparam logic [8:0] Y400_INIT = 9'd370;
  localparam logic [6:0] Y100_LAST = 7'd99;
  localparam logic [8:0] Y400_LAST = 9'd399;

  localparam logic [3:0] LAST_MONTH = 4'd11;
  localparam logic [3:0] MARCH_IDX  = 4'd2;

  localparam logic [YD_W-1:0] MONTH_START [13] = '{
    9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151, 9'd181,
    9'd212, 9'd243, 9'd273, 9'd304, 9'd334, 9'd365
  };

  localparam logic OP_SET  = 1'b0;
  localparam logic OP_READ = 1'b1;

  localparam logic [1:0] CODE_NONE   = 2'd0;
  localparam logic [1:0] CODE_INSERT = 2'd1;
  localparam logic [1:0] CODE_DELETE = 2'd2;
  localparam logic [1:0] CODE_ALARM  = 2'd3;

  typedef struct packed {
    logic             opcode;
    logic [SEC_W-1:0] raw_seconds;
    logic [1:0]       leap_code;
  } in_word_t;

  typedef struct packed {
    logic [SEC_W-1:0] corrected_seconds;
    logic             second_sixty;
    logic [1:0]       effective_code;
    logic [SEC_W-1:0] leap_point_out;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;        // capture input word
    logic div_step;    // latch day count
    logic year_init;
    logic year_step;
    logic month_step;
    logic nsd_load;    // latch first day of next month
    logic mul;
    logic store;       // write leap point
    logic ans_load;    // fill output register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic walk;        // incoming word is a set with nonzero code
    logic year_done;
    logic month_done;
  } sts_t;

endpackage

// File: rtl/lsca_dp.sv
// Datapath: day divider, year/month walk, leap point store and answer logic.
`timescale 1ns / 1ps
module lsca_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  lsca_pkg::in_word_t  in_word,
  input  lsca_pkg::cmd_t      cmd,
  output lsca_pkg::sts_t      sts,
  output lsca_pkg::out_word_t out_word
);

  logic [lsca_pkg::SEC_W-1:0]  raw_r;
  logic [1:0]                  code_r;
  logic [lsca_pkg::SEC_W-1:0]  lp_r;
  logic [lsca_pkg::DAYS_W-1:0] quo_r;
  logic [lsca_pkg::DAYS_W-1:0] rest_r;
  logic [1:0]                  y4_r;
  logic [6:0]                  y100_r;
  logic [8:0]                  y400_r;
  logic [3:0]                  mon_r;
  logic [lsca_pkg::DAYS_W-1:0] nsd_r;
  logic [lsca_pkg::PROD_W-1:0] prod_r;
  lsca_pkg::out_word_t         out_r;

  logic [lsca_pkg::DPROD_W-1:0] day_prod;
  logic                        leap_yr;
  logic [lsca_pkg::YD_W-1:0]   year_len;
  logic [3:0]                  mon_nx;
  logic [lsca_pkg::YD_W-1:0]   next_start;
  logic [lsca_pkg::SEC_W:0]    raw_x;
  logic [lsca_pkg::SEC_W:0]    lp_x;
  logic [lsca_pkg::SEC_W:0]    lp1_x;
  lsca_pkg::out_word_t         ans;

  // days = (raw >> 7) / 675 by reciprocal multiply, exact over the 27-bit range
  assign day_prod = {{lsca_pkg::RECIP_W{1'b0}},
                     raw_r[lsca_pkg::SEC_W-1:lsca_pkg::DAY_SHIFT]} *
                    {{lsca_pkg::HI_W{1'b0}}, lsca_pkg::DAY_RECIP};

  // Gregorian rule from running residues of the year
  assign leap_yr  = (y4_r == 2'd0 && y100_r != 7'd0) || (y400_r == 9'd0);
  assign year_len = leap_yr ? lsca_pkg::LEAP_YEAR_DAYS : lsca_pkg::YEAR_DAYS;

  assign mon_nx     = mon_r + 4'd1;
  assign next_start = lsca_pkg::MONTH_START[mon_nx] +
                      ((mon_nx >= lsca_pkg::MARCH_IDX && leap_yr) ? 9'd1 : 9'd0);

  assign sts.walk       = in_word.opcode == lsca_pkg::OP_SET &&
                          in_word.leap_code != lsca_pkg::CODE_NONE;
  assign sts.year_done  = rest_r < {9'd0, year_len};
  assign sts.month_done = rest_r < {9'd0, next_start} || mon_r >= lsca_pkg::LAST_MONTH;

  // answer from the current state
  assign raw_x = {1'b0, raw_r};
  assign lp_x  = {1'b0, lp_r};
  assign lp1_x = lp_x + 35'd1;

  always_comb begin
    ans.corrected_seconds = raw_r;
    ans.second_sixty      = 1'b0;
    ans.effective_code    = code_r;
    ans.leap_point_out    = lp_r;
    unique case (code_r)
      lsca_pkg::CODE_INSERT: begin
        if (raw_x > lp_x) ans.corrected_seconds = raw_r - 34'd1;
        if (raw_x == lp1_x) ans.second_sixty = 1'b1;
        if (raw_x > lp1_x) ans.effective_code = lsca_pkg::CODE_NONE;
      end
      lsca_pkg::CODE_DELETE: begin
        if (raw_r >= lp_r) begin
          ans.corrected_seconds = (raw_r == lsca_pkg::SEC_MAX) ? lsca_pkg::SEC_MAX
                                                               : raw_r + 34'd1;
          ans.effective_code    = lsca_pkg::CODE_NONE;
        end
      end
      lsca_pkg::CODE_NONE, lsca_pkg::CODE_ALARM: begin
      end
      default: begin
      end
    endcase
  end

  // leap state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= lsca_pkg::CODE_NONE;
      lp_r   <= '0;
    end else begin
      if (cmd.load && in_word.opcode == lsca_pkg::OP_SET) code_r <= in_word.leap_code;
      if (cmd.store) begin
        lp_r <= (prod_r > lsca_pkg::PROD_LIM) ? lsca_pkg::SEC_MAX
                                              : lsca_pkg::SEC_W'(prod_r - 35'd1);
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) raw_r <= in_word.raw_seconds;
    if (cmd.div_step) quo_r <= day_prod[lsca_pkg::DPROD_W-1:lsca_pkg::RECIP_SHIFT];
    if (cmd.year_init) begin
      rest_r <= quo_r;
      y4_r   <= lsca_pkg::Y4_INIT;
      y100_r <= lsca_pkg::Y100_INIT;
      y400_r <= lsca_pkg::Y400_INIT;
      mon_r  <= '0;
    end
    if (cmd.year_step) begin
      rest_r <= rest_r - {9'd0, year_len};
      y4_r   <= y4_r + 2'd1;
      y100_r <= (y100_r == lsca_pkg::Y100_LAST) ? 7'd0 : y100_r + 7'd1;
      y400_r <= (y400_r == lsca_pkg::Y400_LAST) ? 9'd0 : y400_r + 9'd1;
    end
    if (cmd.month_step) mon_r <= mon_nx;
    if (cmd.nsd_load) nsd_r <= quo_r - rest_r + {9'd0, next_start};
    if (cmd.mul) begin
      prod_r <= {{(lsca_pkg::PROD_W - lsca_pkg::DAYS_W){1'b0}}, nsd_r} *
                {{(lsca_pkg::PROD_W - lsca_pkg::REM_W){1'b0}}, lsca_pkg::DAY_SECS};
    end
    if (cmd.ans_load) out_r <= ans;
  end

  assign out_word = out_r;

endmodule

// File: rtl/lsca_ctrl.sv
// Controller: sequences leap sets through divide, walks, multiply and answer.
`timescale 1ns / 1ps
module lsca_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  lsca_pkg::sts_t sts,
  output lsca_pkg::cmd_t cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DIV   = 8'b0000_0010,
    S_YINIT = 8'b0000_0100,
    S_YEAR  = 8'b0000_1000,
    S_MONTH = 8'b0001_0000,
    S_MUL   = 8'b0010_0000,
    S_STORE = 8'b0100_0000,
    S_ANS   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.walk ? S_DIV : S_ANS;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        state_nxt    = S_YINIT;
      end
      S_YINIT: begin
        cmd.year_init = 1'b1;
        state_nxt     = S_YEAR;
      end
      S_YEAR: begin
        if (sts.year_done) state_nxt = S_MONTH;
        else cmd.year_step = 1'b1;
      end
      S_MONTH: begin
        if (sts.month_done) begin
          cmd.nsd_load = 1'b1;
          state_nxt    = S_MUL;
        end else begin
          cmd.month_step = 1'b1;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_STORE;
      end
      S_STORE: begin
        cmd.store = 1'b1;
        state_nxt = S_ANS;
      end
      S_ANS: begin
        if (out_free) begin
          cmd.ans_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.ans_load) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

endmodule

// File: rtl/leap_second_clock_adjust.sv
// Top level of the NTP leap second adjust block.
`timescale 1ns / 1ps
// Leap second adjust. Each input word is a set (opcode 0) or a read (opcode 1)
// and yields exactly one output word. A set stores the 2-bit leap code; with a
// nonzero code it also computes the leap point, the last second of the UTC
// month holding raw_seconds, and stores it (saturated to 2^34-1). Every word
// answers with raw_seconds corrected by the stored code, the 23:59:60 flag,
// the effective code (0 once the leap is past) and the stored leap point.
// One word is in work at a time; in_stall is high from acceptance until the
// answer moves into the output register, which holds it while out_stall is
// high, so the next word can be taken while the last answer waits.
// Sequence: a read, or a set with code 0, is accepted and then answered. A set
// with a nonzero code is accepted, then divided by 86400 (shift by 7, then a
// reciprocal multiply for 675), then initialises the walk, walks whole years
// from 1970 one year per step (up to 544) and months one per step (up to 11),
// then ends each walk, multiplies, stores and answers. A held answer delays
// the answer of the next word until out_stall falls.
module leap_second_clock_adjust (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  lsca_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output lsca_pkg::out_word_t out_word
);

`include "leap_second_clock_adjust_assert.svh"

  lsca_pkg::cmd_t cmd;
  lsca_pkg::sts_t sts;

  lsca_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  lsca_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .cmd      (cmd),
    .sts      (sts),
    .out_word (out_word)
  );

  // an accepted word blocks the input until answered
  `LSCA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  // a new answer always shows up as valid
  `LSCA_ASSERT_NEXT(a_answer_valid, cmd.ans_load, out_valid)
  // a held answer is never overwritten
  `LSCA_ASSERT_SAME(a_no_overwrite, out_valid && out_stall, !cmd.ans_load)
  // a taken answer with nothing behind it leaves the port empty
  `LSCA_ASSERT_NEXT(a_drain, out_valid && !out_stall && !cmd.ans_load, !out_valid)

endmodule
